/* sv/pap_pkg.sv */
`default_nettype none
package pap_pkg;

    // Field widths fixed by the stream format
    localparam int COORD_BITS  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int AREA_W      = 42;
    localparam int PERIM_W     = 35;
    localparam int COUNT_OUT_W = 11;
    localparam int OUT_TDATA_W = AREA_W + PERIM_W + COUNT_OUT_W;

    // Datapath widths
    localparam int MUL_W      = COORD_BITS + 1;   // signed coordinate differences
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SQ_SUM_W   = PROD_W + 1;       // dx^2 + dy^2
    localparam int ROOT_PAIRS = (SQ_SUM_W + 1) / 2;
    localparam int CROSS_W    = AREA_W + 1;

    localparam logic signed [CROSS_W-1:0] CROSS_LIMIT = CROSS_W'((64'd1 << AREA_W) - 64'd1);
    localparam logic [PERIM_W-1:0]        PERIM_LIMIT = '1;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_FRAC_BITS    = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_MUL,
        ST_DIFF,
        ST_ROOT,
        ST_ACC,
        ST_EMIT
    } pap_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } pap_mul_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } pap_root_ctrl_t;

endpackage
`default_nettype wire

/* sv/pap_smul.sv */
`default_nettype none
// Bit-serial signed multiplier, multiplier bits taken LSB first.
// The sign bit of the multiplier has negative weight, so the last step subtracts.
module pap_smul #(
    parameter int W = pap_pkg::MUL_W
) (
    input  wire                       clk,
    input  wire pap_pkg::pap_mul_ctrl_t ctrl,
    input  wire logic signed [W-1:0]  a,
    input  wire logic signed [W-1:0]  b,
    output logic signed [2*W-1:0]     p
);

    logic signed [W:0]   hi_reg;
    logic signed [W:0]   hi_next;
    logic [W-1:0]        lo_reg;
    logic [W-1:0]        lo_next;
    logic signed [W-1:0] a_reg;
    logic signed [W-1:0] a_next;
    logic signed [W:0]   addend;
    logic signed [W:0]   sum;

    always_comb
    begin
        addend  = lo_reg[0] ? {a_reg[W-1], a_reg} : '0;
        sum     = ctrl.last ? (hi_reg - addend) : (hi_reg + addend);
        hi_next = hi_reg;
        lo_next = lo_reg;
        a_next  = a_reg;
        if (ctrl.load)
        begin
            hi_next = '0;
            lo_next = b;
            a_next  = a;
        end
        else if (ctrl.step)
        begin
            hi_next = {sum[W], sum[W:1]};
            lo_next = {sum[0], lo_reg[W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign p = {hi_reg[W-1:0], lo_reg};

endmodule
`default_nettype wire

/* sv/pap_root.sv */
`default_nettype none
// Restoring square root, one result bit per cycle while ctrl.step is high.
// Gives floor(sqrt(n) * 2^FRAC_BITS) after RW steps.
module pap_root #(
    parameter int FRAC_BITS = pap_pkg::DEF_FRAC_BITS,
    parameter int RW        = pap_pkg::ROOT_PAIRS + FRAC_BITS
) (
    input  wire                               clk,
    input  wire pap_pkg::pap_root_ctrl_t      ctrl,
    input  wire logic [pap_pkg::SQ_SUM_W-1:0] n,
    output logic [RW-1:0]                     root
);

    localparam int SRW = 2 * RW;

    logic [SRW-1:0] sr_reg;
    logic [SRW-1:0] sr_next;
    logic [RW:0]    rem_reg;
    logic [RW:0]    rem_next;
    logic [RW-1:0]  root_reg;
    logic [RW-1:0]  root_next;
    logic [RW+2:0]  rem_shift;
    logic [RW+2:0]  trial;
    logic [RW+2:0]  diff;
    logic           ge;

    always_comb
    begin
        rem_shift = {rem_reg, sr_reg[SRW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_shift - trial;
        ge        = (rem_shift >= trial);
        sr_next   = sr_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctrl.load)
        begin
            sr_next   = SRW'(n) << (2 * FRAC_BITS);
            rem_next  = '0;
            root_next = '0;
        end
        else if (ctrl.step)
        begin
            sr_next   = {sr_reg[SRW-3:0], 2'b00};
            rem_next  = ge ? diff[RW:0] : rem_shift[RW:0];
            root_next = {root_reg[RW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg   <= sr_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule
`default_nettype wire

/* sv/polygon_area_perimeter.sv */
// Polygon area and perimeter from a stream of vertices.
// Slave stream: one vertex per item, tdata = {y, x} (x in the low 16 bits),
// tlast marks the final vertex of a polygon. Non-final vertices give no result.
// Master stream: one item per polygon on its final vertex; tdata holds twice
// the absolute area, the perimeter with FRAC_BITS fraction bits and the vertex
// count; tuser flags a count that ran past MAX_VERTICES.
// Each edge runs through four bit-serial multipliers and then a restoring
// square root, one bit a cycle, with setup and accumulation around them.
// The final vertex also works the closing edge and then writes the output
// register.
// One vertex is in work at a time; tready is high while the block is idle.
// The result sits in an output register, so the next polygon's vertices are
// taken while it waits; only a new result stalls until the old one is taken.
// Reset clears all polygon state and drops tvalid on the master side.
`default_nettype none
module polygon_area_perimeter #(
    parameter int MAX_VERTICES = pap_pkg::DEF_MAX_VERTICES,
    parameter int FRAC_BITS    = pap_pkg::DEF_FRAC_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // vertex_x, vertex_y
    input  wire logic [pap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire                                  s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // area_doubled, perimeter_fixed, vertex_count
    output logic [pap_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // count_overflow
    output logic                                 m_axis_tuser
);

    localparam int CB     = pap_pkg::COORD_BITS;
    localparam int MW     = pap_pkg::MUL_W;
    localparam int PW     = pap_pkg::PROD_W;
    localparam int RW     = pap_pkg::ROOT_PAIRS + FRAC_BITS;
    localparam int STEP_W = $clog2(RW);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int CW     = pap_pkg::CROSS_W;

    pap_pkg::pap_state_t state_reg, state_next;

    logic signed [CB-1:0] cur_x_reg, cur_y_reg, cur_x_next, cur_y_next;
    logic signed [CB-1:0] first_x_reg, first_y_reg, first_x_next, first_y_next;
    logic signed [CB-1:0] prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic signed [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [CB-1:0] ax_next, ay_next, bx_next, by_next;
    logic                 last_reg, last_next;
    logic                 edge1_reg, edge1_next;
    logic                 edge2_reg, edge2_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic signed [PW-1:0] cross_reg, cross_next;
    logic signed [CW-1:0] cross_sum_reg, cross_sum_next;
    logic [pap_pkg::PERIM_W-1:0] length_sum_reg, length_sum_next;

    logic                            out_valid_reg, out_valid_next;
    logic [pap_pkg::AREA_W-1:0]      out_area_reg, out_area_next;
    logic [pap_pkg::PERIM_W-1:0]     out_perim_reg, out_perim_next;
    logic [pap_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic                            out_ovf_reg, out_ovf_next;

    pap_pkg::pap_mul_ctrl_t  mul_ctrl;
    pap_pkg::pap_root_ctrl_t root_ctrl;

    logic                 in_take;
    logic                 out_free;
    logic                 mul_done;
    logic                 root_done;
    logic signed [MW-1:0] dx, dy, ux, uy;
    logic signed [MW-1:0] ax_w, ay_w, bx_w, by_w;
    logic signed [PW-1:0] p_ab, p_ba, p_xx, p_yy;
    logic [pap_pkg::SQ_SUM_W-1:0] sq_sum;
    logic [RW-1:0]        root;
    logic signed [CW:0]   acc_sum;
    logic [pap_pkg::PERIM_W:0] len_sum;
    logic [CW-1:0]        area_abs;
    logic [CNT_W+pap_pkg::COUNT_OUT_W-1:0] count_ext;

    // Operand preparation
    always_comb
    begin
        ax_w = {ax_reg[CB-1], ax_reg};
        ay_w = {ay_reg[CB-1], ay_reg};
        bx_w = {bx_reg[CB-1], bx_reg};
        by_w = {by_reg[CB-1], by_reg};
        dx   = bx_w - ax_w;
        dy   = by_w - ay_w;
        ux   = dx[MW-1] ? -dx : dx;
        uy   = dy[MW-1] ? -dy : dy;
    end

    pap_smul #(.W(MW)) u_mul_ab (.clk(clk), .ctrl(mul_ctrl), .a(ax_w), .b(by_w), .p(p_ab));
    pap_smul #(.W(MW)) u_mul_ba (.clk(clk), .ctrl(mul_ctrl), .a(bx_w), .b(ay_w), .p(p_ba));
    pap_smul #(.W(MW)) u_mul_xx (.clk(clk), .ctrl(mul_ctrl), .a(ux), .b(ux), .p(p_xx));
    pap_smul #(.W(MW)) u_mul_yy (.clk(clk), .ctrl(mul_ctrl), .a(uy), .b(uy), .p(p_yy));

    assign sq_sum = {1'b0, p_xx} + {1'b0, p_yy};

    pap_root #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_root (
        .clk  (clk),
        .ctrl (root_ctrl),
        .n    (sq_sum),
        .root (root)
    );

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign mul_done  = (step_reg == STEP_W'(MW - 1));
    assign root_done = (step_reg == STEP_W'(RW - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pap_pkg::ST_IDLE:
            begin
                if (in_take)
                    state_next = pap_pkg::ST_SETUP;
            end
            pap_pkg::ST_SETUP:
            begin
                if (edge1_reg || edge2_reg)
                    state_next = pap_pkg::ST_LOAD;
                else if (last_reg)
                    state_next = pap_pkg::ST_EMIT;
                else
                    state_next = pap_pkg::ST_IDLE;
            end
            pap_pkg::ST_LOAD: state_next = pap_pkg::ST_MUL;
            pap_pkg::ST_MUL:
            begin
                if (mul_done)
                    state_next = pap_pkg::ST_DIFF;
            end
            pap_pkg::ST_DIFF: state_next = pap_pkg::ST_ROOT;
            pap_pkg::ST_ROOT:
            begin
                if (root_done)
                    state_next = pap_pkg::ST_ACC;
            end
            pap_pkg::ST_ACC: state_next = pap_pkg::ST_SETUP;
            pap_pkg::ST_EMIT:
            begin
                if (out_free)
                    state_next = pap_pkg::ST_IDLE;
            end
            default: state_next = pap_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready  = 1'b0;
        mul_ctrl       = '0;
        root_ctrl      = '0;
        case (state_reg)
            pap_pkg::ST_IDLE: s_axis_tready = 1'b1;
            pap_pkg::ST_LOAD: mul_ctrl.load = 1'b1;
            pap_pkg::ST_MUL:
            begin
                mul_ctrl.step = 1'b1;
                mul_ctrl.last = mul_done;
            end
            pap_pkg::ST_DIFF: root_ctrl.load = 1'b1;
            pap_pkg::ST_ROOT: root_ctrl.step = 1'b1;
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        last_next       = last_reg;
        edge1_next      = edge1_reg;
        edge2_next      = edge2_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        cross_next      = cross_reg;
        cross_sum_next  = cross_sum_reg;
        length_sum_next = length_sum_reg;
        out_valid_next  = out_valid_reg;
        out_area_next   = out_area_reg;
        out_perim_next  = out_perim_reg;
        out_count_next  = out_count_reg;
        out_ovf_next    = out_ovf_reg;

        acc_sum   = {cross_sum_reg[CW-1], cross_sum_reg} + (CW + 1)'(cross_reg);
        len_sum   = {1'b0, length_sum_reg} + (pap_pkg::PERIM_W + 1)'(root);
        area_abs  = cross_sum_reg[CW-1] ? CW'(-cross_sum_reg) : CW'(cross_sum_reg);
        count_ext = (CNT_W + pap_pkg::COUNT_OUT_W)'(count_reg);

        if (m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            pap_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    cur_x_next = s_axis_tdata[CB-1:0];
                    cur_y_next = s_axis_tdata[2*CB-1:CB];
                    last_next  = s_axis_tlast;
                    edge2_next = s_axis_tlast;
                    edge1_next = (count_reg != '0);
                    if (count_reg == '0)
                    begin
                        first_x_next = s_axis_tdata[CB-1:0];
                        first_y_next = s_axis_tdata[2*CB-1:CB];
                        count_next   = CNT_W'(1);
                    end
                    else if (count_reg < CNT_W'(MAX_VERTICES))
                        count_next = count_reg + CNT_W'(1);
                    else
                        ovf_next = 1'b1;
                end
            end
            pap_pkg::ST_SETUP:
            begin
                step_next = '0;
                if (edge1_reg)
                begin
                    ax_next    = prev_x_reg;
                    ay_next    = prev_y_reg;
                    bx_next    = cur_x_reg;
                    by_next    = cur_y_reg;
                    edge1_next = 1'b0;
                end
                else if (edge2_reg)
                begin
                    ax_next    = cur_x_reg;
                    ay_next    = cur_y_reg;
                    bx_next    = first_x_reg;
                    by_next    = first_y_reg;
                    edge2_next = 1'b0;
                end
                else if (!last_reg)
                begin
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                end
            end
            pap_pkg::ST_MUL:
            begin
                step_next = mul_done ? '0 : step_reg + STEP_W'(1);
            end
            pap_pkg::ST_DIFF:
            begin
                cross_next = p_ab - p_ba;
            end
            pap_pkg::ST_ROOT:
            begin
                step_next = root_done ? '0 : step_reg + STEP_W'(1);
            end
            pap_pkg::ST_ACC:
            begin
                // saturate the shoelace sum symmetrically
                if (acc_sum > (CW + 1)'(pap_pkg::CROSS_LIMIT))
                    cross_sum_next = pap_pkg::CROSS_LIMIT;
                else if (acc_sum < -((CW + 1)'(pap_pkg::CROSS_LIMIT)))
                    cross_sum_next = -pap_pkg::CROSS_LIMIT;
                else
                    cross_sum_next = acc_sum[CW-1:0];
                if (len_sum > (pap_pkg::PERIM_W + 1)'(pap_pkg::PERIM_LIMIT))
                    length_sum_next = pap_pkg::PERIM_LIMIT;
                else
                    length_sum_next = len_sum[pap_pkg::PERIM_W-1:0];
            end
            pap_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_area_next   = area_abs[pap_pkg::AREA_W-1:0];
                    out_perim_next  = length_sum_reg;
                    out_count_next  = count_ext[pap_pkg::COUNT_OUT_W-1:0];
                    out_ovf_next    = ovf_reg;
                    // fresh polygon
                    first_x_next    = '0;
                    first_y_next    = '0;
                    prev_x_next     = '0;
                    prev_y_next     = '0;
                    cross_sum_next  = '0;
                    length_sum_next = '0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    last_next       = 1'b0;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pap_pkg::ST_IDLE;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            last_reg       <= 1'b0;
            edge1_reg      <= 1'b0;
            edge2_reg      <= 1'b0;
            step_reg       <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            cross_sum_reg  <= '0;
            length_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            last_reg       <= last_next;
            edge1_reg      <= edge1_next;
            edge2_reg      <= edge2_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            cross_sum_reg  <= cross_sum_next;
            length_sum_reg <= length_sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        cross_reg     <= cross_next;
        out_area_reg  <= out_area_next;
        out_perim_reg <= out_perim_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_perim_reg, out_area_reg};
    assign m_axis_tuser  = out_ovf_reg;

endmodule
`default_nettype wire

/* dv/polygon_area_perimeter_checker.sv */
module polygon_area_perimeter_checker #(
    parameter int MAX_VERTICES = pap_pkg::DEF_MAX_VERTICES,
    parameter int FRAC_BITS    = pap_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    // vertex_x, vertex_y
    input  wire logic [pap_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                           s_axis_tlast,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // area_doubled, perimeter_fixed, vertex_count
    input  wire logic [pap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // count_overflow
    input  wire logic                           m_axis_tuser,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pap_pkg::AREA_W-1:0]      area_doubled;
        logic [pap_pkg::PERIM_W-1:0]     perimeter_fixed;
        logic [pap_pkg::COUNT_OUT_W-1:0] vertex_count;
        logic                            count_overflow;
    } polygon_result_t;

    localparam longint            AREA_SAT  = longint'(pap_pkg::CROSS_LIMIT);
    localparam longint unsigned   PERIM_SAT = longint'(pap_pkg::PERIM_LIMIT);

    polygon_result_t   polygon_results[$];

    // polygon in progress
    longint            first_x, first_y, prev_x, prev_y;
    longint            shoelace_sum;
    longint unsigned   perimeter_sum;
    int                vertices_seen;
    logic              too_many;

    // floor(sqrt(dx^2 + dy^2) * 2^FRAC_BITS), one bit at a time from the top
    function automatic longint unsigned edge_length_fixed(input longint dx, input longint dy);
        logic [95:0] target;
        logic [47:0] root;
        logic [47:0] trial;
        target = 96'(dx * dx + dy * dy) << (2 * FRAC_BITS);
        root   = '0;
        for (int b = 47; b >= 0; b--)
        begin
            trial = root | (48'd1 << b);
            if (96'(trial) * 96'(trial) <= target)
                root = trial;
        end
        return longint'(root);
    endfunction

    function automatic void fold_edge(input longint ax, input longint ay,
                                      input longint bx, input longint by);
        longint unsigned len;
        len = edge_length_fixed(bx - ax, by - ay);
        shoelace_sum += ax * by - bx * ay;
        if (shoelace_sum > AREA_SAT)
            shoelace_sum = AREA_SAT;
        if (shoelace_sum < -AREA_SAT)
            shoelace_sum = -AREA_SAT;
        if (len >= PERIM_SAT || perimeter_sum + len > PERIM_SAT)
            perimeter_sum = PERIM_SAT;
        else
            perimeter_sum += len;
    endfunction

    function automatic void clear_polygon();
        first_x       = 0;
        first_y       = 0;
        prev_x        = 0;
        prev_y        = 0;
        shoelace_sum  = 0;
        perimeter_sum = 0;
        vertices_seen = 0;
        too_many      = 1'b0;
    endfunction

    function automatic void absorb_vertex(input logic [pap_pkg::IN_TDATA_W-1:0] item,
                                          input logic is_last);
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        longint             x;
        longint             y;
        polygon_result_t    res;
        vx = item[15:0];
        vy = item[31:16];
        x  = longint'(vx);
        y  = longint'(vy);
        if (vertices_seen == 0)
        begin
            first_x       = x;
            first_y       = y;
            vertices_seen = 1;
        end
        else
        begin
            fold_edge(prev_x, prev_y, x, y);
            if (vertices_seen < MAX_VERTICES)
                vertices_seen++;
            else
                too_many = 1'b1;
        end
        prev_x = x;
        prev_y = y;
        if (is_last)
        begin
            // closing edge back to the first vertex
            fold_edge(x, y, first_x, first_y);
            res.area_doubled    = pap_pkg::AREA_W'(shoelace_sum < 0 ? -shoelace_sum
                                                                    : shoelace_sum);
            res.perimeter_fixed = pap_pkg::PERIM_W'(perimeter_sum);
            res.vertex_count    = pap_pkg::COUNT_OUT_W'(vertices_seen);
            res.count_overflow  = too_many;
            polygon_results.push_back(res);
            clear_polygon();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        polygon_result_t want;
        polygon_result_t got;
        if (!rst_n)
        begin
            clear_polygon();
            polygon_results.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.area_doubled    = m_axis_tdata[pap_pkg::AREA_W-1:0];
                got.perimeter_fixed = m_axis_tdata[pap_pkg::AREA_W +: pap_pkg::PERIM_W];
                got.vertex_count    =
                    m_axis_tdata[pap_pkg::AREA_W + pap_pkg::PERIM_W +: pap_pkg::COUNT_OUT_W];
                got.count_overflow  = m_axis_tuser;
                if (polygon_results.size() == 0)
                begin
                    $error("result item with no polygon outstanding: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = polygon_results.pop_front();
                    if (got.area_doubled !== want.area_doubled)
                    begin
                        $error("area_doubled: expected %0d, got %0d",
                               want.area_doubled, got.area_doubled);
                        fail_count++;
                    end
                    if (got.perimeter_fixed !== want.perimeter_fixed)
                    begin
                        $error("perimeter_fixed: expected %0d, got %0d",
                               want.perimeter_fixed, got.perimeter_fixed);
                        fail_count++;
                    end
                    if (got.vertex_count !== want.vertex_count)
                    begin
                        $error("vertex_count: expected %0d, got %0d",
                               want.vertex_count, got.vertex_count);
                        fail_count++;
                    end
                    if (got.count_overflow !== want.count_overflow)
                    begin
                        $error("count_overflow: expected %0b, got %0b",
                               want.count_overflow, got.count_overflow);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_vertex(s_axis_tdata, s_axis_tlast);
            pending <= polygon_results.size();
        end
    end

endmodule

/* dv/polygon_area_perimeter_tb.sv */
module polygon_area_perimeter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_NEAR,
        SPREAD_CORNERS
    } coord_spread_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [pap_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [pap_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    int fail_count;
    int pending;
    int quiet_cycles;
    int random_vertices;
    bit idle_on;

    polygon_area_perimeter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    polygon_area_perimeter_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_axis_tready <= !idle_on || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_vertex(input int vx, input int vy, input logic is_last);
        if (idle_on && $urandom_range(99) < 34)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 34);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {16'(vy), 16'(vx)};
        s_axis_tlast  <= is_last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic int pick_coord(input coord_spread_t spread);
        case (spread)
            SPREAD_FULL: return int'($signed(16'($urandom)));
            SPREAD_NEAR: return int'($urandom_range(127)) - 64;
            default:
                case ($urandom_range(4))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return 0;
                    3:       return -1;
                    default: return int'($signed(16'($urandom)));
                endcase
        endcase
    endfunction

    task automatic send_random_polygon(input int n_vertices);
        coord_spread_t spread;
        spread = coord_spread_t'($urandom_range(2));
        for (int k = 1; k <= n_vertices; k++)
            send_vertex(pick_coord(spread), pick_coord(spread), k == n_vertices);
        random_vertices += n_vertices;
    endtask

    task automatic send_small_polygons(input int until_total);
        while (random_vertices < until_total)
            send_random_polygon(($urandom_range(9) == 0) ? $urandom_range(1, 2)
                                                         : $urandom_range(3, 12));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        idle_on         = 1'b1;
        quiet_cycles    = 0;
        random_vertices = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertex polygons: nothing to enclose, nothing to walk
        send_vertex(32767, -32768, 1'b1);
        send_vertex(-32768, -32768, 1'b1);
        // 3-4-5 triangle, anticlockwise then clockwise
        send_vertex(0, 0, 1'b0);
        send_vertex(3, 0, 1'b0);
        send_vertex(0, 4, 1'b1);
        send_vertex(0, 0, 1'b0);
        send_vertex(0, 4, 1'b0);
        send_vertex(3, 0, 1'b1);
        // two vertices: longest possible edge, walked twice
        send_vertex(-32768, 32767, 1'b0);
        send_vertex(32767, -32768, 1'b1);
        // full-range square
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(32767, -32768, 1'b0);
        send_vertex(32767, 32767, 1'b0);
        send_vertex(-32768, 32767, 1'b1);
        // irrational edges
        send_vertex(32767, 32767, 1'b0);
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(1, -2, 1'b1);

        // hold off until the block has handed over everything
        drain_results();

        idle_on = 1'b0;
        send_small_polygons(60);
        idle_on = 1'b1;
        send_small_polygons(120);
        // count runs right up to the limit, then one past it
        send_random_polygon(pap_pkg::DEF_MAX_VERTICES);
        send_random_polygon(pap_pkg::DEF_MAX_VERTICES + 1);

        drain_results();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
